/* rtl/pmt_section_parser_top_defines.svh */
// assertion macros for the program map section parser
// used by the top level; expects clk and rst_n in the including scope
`ifndef PMT_SECTION_PARSER_TOP_DEFINES_SVH
`define PMT_SECTION_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMT_ASSERT_IMPL(lbl, ante, cons, msg)
`define PMT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/pmt_pkg.sv */
// shared types and constants of the program map section parser
// no dependencies
`default_nettype none

package pmt_pkg;

  localparam int MAX_PAYLOAD_BYTES = 1024;
  // position counter must hold the overflow mark one past the limit
  localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 2);

  localparam logic [7:0]  TID_PMT  = 8'h02;
  localparam logic [15:0] PCR_NONE = 16'hFFFF;
  localparam logic [7:0]  CNT_MAX  = 8'hFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_TID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  stream_type;
    logic [12:0] es_pid;
    logic [11:0] es_info_length;
    logic [7:0]  entry_index;
    logic [15:0] pcr_pid;
    logic [7:0]  entry_count;
    logic [1:0]  status;
    logic        final_res;
  } res_t;

  // results produced by one accepted byte: none, one (a) or two (a then b)
  typedef struct packed {
    logic en;
    logic two;
    res_t a;
    res_t b;
  } push_t;

endpackage

`default_nettype wire

/* rtl/pmt_parser.sv */
// section byte parser: parse state registers and per-byte result build
// depends on pmt_pkg
`default_nettype none

module pmt_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    table_id,
  input  wire logic [7:0]    data_byte,
  input  wire logic          first_byte,
  input  wire logic          last_byte,
  output pmt_pkg::push_t     push
);
  import pmt_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_PROGSKIP, PH_TYPE, PH_PIDHI,
    PH_PIDLO, PH_LENHI, PH_LENLO, PH_ESSKIP
  } phase_t;

  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_OVER = POS_W'(MAX_PAYLOAD_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_s, pos_u;
  phase_t           phase_r, phase_nxt, phase_s, phase_u;
  logic [11:0]      skip_r, skip_nxt, skip_s, skip_u, skip_dec;
  logic [15:0]      pcr_r, pcr_nxt, pcr_s, pcr_u;
  logic [7:0]       stype_r, stype_nxt, stype_s, stype_u;
  logic [12:0]      epid_r, epid_nxt, epid_s, epid_u;
  logic [7:0]       cnt_r, cnt_nxt, cnt_s, cnt_u;
  logic             rej_r, rej_nxt, rej_s, rej_u;
  logic             emit_entry;
  logic [1:0]       status;
  res_t             entry_res, sum_res;

  always_comb begin
    // a first byte restarts the section before it is parsed
    pos_s   = first_byte ? '0 : pos_r;
    phase_s = first_byte ? PH_HEADER : phase_r;
    skip_s  = first_byte ? '0 : skip_r;
    pcr_s   = first_byte ? PCR_NONE : pcr_r;
    stype_s = first_byte ? '0 : stype_r;
    epid_s  = first_byte ? '0 : epid_r;
    cnt_s   = first_byte ? '0 : cnt_r;
    rej_s   = first_byte ? 1'b0 : rej_r;

    rej_u      = rej_s | (table_id != TID_PMT);
    pos_u      = pos_s;
    phase_u    = phase_s;
    skip_u     = skip_s;
    pcr_u      = pcr_s;
    stype_u    = stype_s;
    epid_u     = epid_s;
    cnt_u      = cnt_s;
    emit_entry = 1'b0;
    skip_dec   = (skip_s != '0) ? skip_s - 12'd1 : skip_s;

    if (!rej_u) begin
      if (pos_s >= POS_MAX) begin
        pos_u = POS_OVER;
      end else begin
        pos_u = pos_s + POS_W'(1);
        case (phase_s)
          PH_HEADER: begin
            if (pos_s == POS_W'(0)) begin
              epid_u = {8'd0, data_byte[4:0]};
            end else if (pos_s == POS_W'(1)) begin
              pcr_u  = {epid_s[7:0], data_byte};
              epid_u = '0;
            end else if (pos_s == POS_W'(2)) begin
              skip_u = {data_byte[3:0], 8'd0};
            end else begin
              skip_u  = {skip_s[11:8], data_byte};
              phase_u = ({skip_s[11:8], data_byte} != 12'd0) ? PH_PROGSKIP : PH_TYPE;
            end
          end
          PH_PROGSKIP, PH_ESSKIP: begin
            skip_u = skip_dec;
            if (skip_dec == 12'd0) phase_u = PH_TYPE;
          end
          PH_TYPE: begin
            stype_u = data_byte;
            phase_u = PH_PIDHI;
          end
          PH_PIDHI: begin
            epid_u  = {data_byte[4:0], 8'd0};
            phase_u = PH_PIDLO;
          end
          PH_PIDLO: begin
            epid_u  = {epid_s[12:8], data_byte};
            phase_u = PH_LENHI;
          end
          PH_LENHI: begin
            skip_u  = {data_byte[3:0], 8'd0};
            phase_u = PH_LENLO;
          end
          PH_LENLO: begin
            skip_u     = {skip_s[11:8], data_byte};
            emit_entry = 1'b1;
            cnt_u      = (cnt_s != CNT_MAX) ? cnt_s + 8'd1 : cnt_s;
            phase_u    = ({skip_s[11:8], data_byte} != 12'd0) ? PH_ESSKIP : PH_TYPE;
          end
          default: begin
            phase_u = phase_s;
          end
        endcase
      end
    end

    if (rej_u) begin
      status = ST_BAD_TID;
    end else if (pos_u > POS_MAX || phase_u != PH_TYPE) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end

    entry_res                = '0;
    entry_res.kind           = KIND_ENTRY;
    entry_res.stream_type    = stype_s;
    entry_res.es_pid         = epid_u;
    entry_res.es_info_length = skip_u;
    entry_res.entry_index    = cnt_s;
    entry_res.pcr_pid        = pcr_s;
    entry_res.final_res      = !last_byte;

    sum_res             = '0;
    sum_res.kind        = KIND_SUMMARY;
    sum_res.pcr_pid     = rej_u ? PCR_NONE : pcr_u;
    sum_res.entry_count = rej_u ? 8'd0 : cnt_u;
    sum_res.status      = status;
    sum_res.final_res   = 1'b1;

    push.en  = accept & (emit_entry | last_byte);
    push.two = accept & emit_entry & last_byte;
    push.a   = emit_entry ? entry_res : sum_res;
    push.b   = sum_res;

    // after a last byte the parser waits at the start of a new section
    if (last_byte) begin
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      skip_nxt  = '0;
      pcr_nxt   = PCR_NONE;
      stype_nxt = '0;
      epid_nxt  = '0;
      cnt_nxt   = '0;
      rej_nxt   = 1'b0;
    end else begin
      pos_nxt   = pos_u;
      phase_nxt = phase_u;
      skip_nxt  = skip_u;
      pcr_nxt   = pcr_u;
      stype_nxt = stype_u;
      epid_nxt  = epid_u;
      cnt_nxt   = cnt_u;
      rej_nxt   = rej_u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      skip_r  <= '0;
      pcr_r   <= PCR_NONE;
      stype_r <= '0;
      epid_r  <= '0;
      cnt_r   <= '0;
      rej_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      pcr_r   <= pcr_nxt;
      stype_r <= stype_nxt;
      epid_r  <= epid_nxt;
      cnt_r   <= cnt_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/pmt_res_fifo.sv */
// result queue: takes one or two results per cycle, hands out one per cycle while out_ready is high
// depends on pmt_pkg
`default_nettype none

module pmt_res_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pmt_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pmt_pkg::res_t       out_res
);
  import pmt_pkg::*;

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_b;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt, n_push;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  // room for two results regardless of the output side
  assign room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    n_push     = FIFO_CNT_W'(push.en) + FIFO_CNT_W'(push.two);
    wr_ptr_b   = wr_ptr_r + FIFO_PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + n_push - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en) mem_r[wr_ptr_r] <= push.a;
    if (push.two) mem_r[wr_ptr_b] <= push.b;
  end

endmodule

`default_nettype wire

/* rtl/pmt_section_parser_top.sv */
// top level of the program map section parser
// depends on pmt_pkg, pmt_parser, pmt_res_fifo and the assertion macro header
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   table_id, data_byte, first_byte, last_byte
//  out_     output     out_valid / out_ready entry or summary result, final_res
//
// one byte is accepted per cycle while in_ready is high; its results enter the result queue
// on the same edge and are offered on out_ from the queue registers, behind any older results
// a byte can cause two results; the four-entry queue drains one per cycle while out_ready
// is high, and in_ready drops only while fewer than two entries are free
// synchronous reset puts the parser at the start of a section and empties the queue
`default_nettype none

`include "pmt_section_parser_top_defines.svh"

module pmt_section_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_table_id,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_stream_type,
  output logic [12:0]      out_es_pid,
  output logic [11:0]      out_es_info_length,
  output logic [7:0]       out_entry_index,
  output logic [15:0]      out_pcr_pid,
  output logic [7:0]       out_entry_count,
  output logic [1:0]       out_status,
  output logic             out_final_res
);
  import pmt_pkg::*;

  logic  accept;
  push_t push;
  res_t  res;

  assign accept = in_valid & in_ready;

  pmt_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .table_id   (in_table_id),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .last_byte  (in_last_byte),
    .push       (push)
  );

  pmt_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind           = res.kind;
  assign out_stream_type    = res.stream_type;
  assign out_es_pid         = res.es_pid;
  assign out_es_info_length = res.es_info_length;
  assign out_entry_index    = res.entry_index;
  assign out_pcr_pid        = res.pcr_pid;
  assign out_entry_count    = res.entry_count;
  assign out_status         = res.status;
  assign out_final_res      = res.final_res;

  `PMT_ASSERT_NEXT(a_last_gives_result, accept && in_last_byte, out_valid, "last byte lost its summary")
  `PMT_ASSERT_IMPL(a_summary_final, out_valid && out_kind == KIND_SUMMARY, out_final_res, "summary not final")
  `PMT_ASSERT_IMPL(a_entry_clean, out_valid && out_kind == KIND_ENTRY, out_status == ST_OK && out_entry_count == 8'd0, "entry carries summary fields")
  `PMT_ASSERT_IMPL(a_reject_summary, out_valid && out_kind == KIND_SUMMARY && out_status == ST_BAD_TID, out_pcr_pid == PCR_NONE && out_entry_count == 8'd0, "rejected summary not cleared")

endmodule

`default_nettype wire

/* verif/pmt_section_parser_checker.sv */
// result checker for the program map section parser testbench
// predicts entry and summary results from accepted bytes and compares them in order
// depends on pmt_pkg
`timescale 1ns / 1ps

module pmt_section_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_table_id,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic [7:0]  out_stream_type,
  input  logic [12:0] out_es_pid,
  input  logic [11:0] out_es_info_length,
  input  logic [7:0]  out_entry_index,
  input  logic [15:0] out_pcr_pid,
  input  logic [7:0]  out_entry_count,
  input  logic [1:0]  out_status,
  input  logic        out_final_res,
  output int          err_cnt,
  output int          expect_cnt
);
  import pmt_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PROG_SKIP,
    PH_TYPE,
    PH_PID_HI,
    PH_PID_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_ES_SKIP
  } phase_e;

  logic [POS_W-1:0] sec_pos;
  phase_e           sec_phase;
  logic [11:0]      skip_left;
  logic [15:0]      pcr_seen;
  logic [7:0]       cur_type;
  logic [12:0]      cur_pid;
  logic [7:0]       n_entries;
  logic             rejected;

  res_t pending_q[$];

  task automatic clear_section();
    sec_pos = '0;
    sec_phase = PH_HEADER;
    skip_left = '0;
    pcr_seen = PCR_NONE;
    cur_type = '0;
    cur_pid = '0;
    n_entries = '0;
    rejected = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] tid, input logic [7:0] b,
                              input logic first, input logic last);
    res_t             ent;
    res_t             summ;
    logic             have_ent;
    logic [POS_W-1:0] here;
    have_ent = 1'b0;
    ent = '0;
    summ = '0;
    if (first)
      clear_section();
    if (tid != TID_PMT)
      rejected = 1'b1;

    if (!rejected) begin
      if (sec_pos >= POS_W'(MAX_PAYLOAD_BYTES)) begin
        // oversize payload: park one past the limit
        sec_pos = POS_W'(MAX_PAYLOAD_BYTES + 1);
      end else begin
        here = sec_pos;
        sec_pos = here + 1'b1;
        case (sec_phase)
          PH_HEADER: begin
            if (here == 0) begin
              cur_pid = {8'h00, b[4:0]};
            end else if (here == 1) begin
              pcr_seen = {3'b000, cur_pid[4:0], b};
              cur_pid = '0;
            end else if (here == 2) begin
              skip_left = {b[3:0], 8'h00};
            end else begin
              skip_left = skip_left | {4'h0, b};
              sec_phase = (skip_left != 0) ? PH_PROG_SKIP : PH_TYPE;
            end
          end
          PH_PROG_SKIP, PH_ES_SKIP: begin
            if (skip_left != 0)
              skip_left = skip_left - 1'b1;
            if (skip_left == 0)
              sec_phase = PH_TYPE;
          end
          PH_TYPE: begin
            cur_type = b;
            sec_phase = PH_PID_HI;
          end
          PH_PID_HI: begin
            cur_pid = {b[4:0], 8'h00};
            sec_phase = PH_PID_LO;
          end
          PH_PID_LO: begin
            cur_pid = cur_pid | {5'h00, b};
            sec_phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            skip_left = {b[3:0], 8'h00};
            sec_phase = PH_LEN_LO;
          end
          default: begin
            skip_left = skip_left | {4'h0, b};
            have_ent = 1'b1;
            ent.kind = KIND_ENTRY;
            ent.stream_type = cur_type;
            ent.es_pid = cur_pid;
            ent.es_info_length = skip_left;
            ent.entry_index = n_entries;
            ent.pcr_pid = pcr_seen;
            ent.entry_count = '0;
            ent.status = ST_OK;
            ent.final_res = !last;
            if (n_entries != CNT_MAX)
              n_entries = n_entries + 1'b1;
            sec_phase = (skip_left != 0) ? PH_ES_SKIP : PH_TYPE;
          end
        endcase
      end
    end

    if (have_ent)
      pending_q.insert(pending_q.size(), ent);

    if (last) begin
      summ.kind = KIND_SUMMARY;
      summ.final_res = 1'b1;
      if (rejected) begin
        // a bad table id outranks truncation
        summ.status = ST_BAD_TID;
        summ.pcr_pid = PCR_NONE;
        summ.entry_count = '0;
      end else begin
        if (sec_pos > POS_W'(MAX_PAYLOAD_BYTES) || sec_phase != PH_TYPE)
          summ.status = ST_TRUNC;
        else
          summ.status = ST_OK;
        summ.pcr_pid = pcr_seen;
        summ.entry_count = n_entries;
      end
      pending_q.insert(pending_q.size(), summ);
      clear_section();
    end
  endtask

  task automatic cmp_field(input string fname, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      clear_section();
      pending_q.delete();
    end else begin
      // the result leaving now was predicted at an earlier edge
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $error("result transfer with nothing expected, kind %0d", out_kind);
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          cmp_field("kind", 16'(want.kind), 16'(out_kind));
          cmp_field("stream_type", 16'(want.stream_type), 16'(out_stream_type));
          cmp_field("es_pid", 16'(want.es_pid), 16'(out_es_pid));
          cmp_field("es_info_length", 16'(want.es_info_length), 16'(out_es_info_length));
          cmp_field("entry_index", 16'(want.entry_index), 16'(out_entry_index));
          cmp_field("pcr_pid", want.pcr_pid, out_pcr_pid);
          cmp_field("entry_count", 16'(want.entry_count), 16'(out_entry_count));
          cmp_field("status", 16'(want.status), 16'(out_status));
          cmp_field("final_res", 16'(want.final_res), 16'(out_final_res));
        end
      end
      if (in_valid && in_ready)
        predict_byte(in_table_id, in_data_byte, in_first_byte, in_last_byte);
    end
    expect_cnt = pending_q.size();
  end

endmodule

/* verif/pmt_section_parser_top_tb.sv */
// testbench top for the program map section parser: clock, reset, byte stimulus, verdict
// drives directed and random sections into pmt_section_parser_top
// depends on pmt_pkg and pmt_section_parser_checker
`timescale 1ns / 1ps

module pmt_section_parser_top_tb;
  import pmt_pkg::*;

  localparam int ITEMS       = 1650;
  localparam int CALM_ITEMS  = 250;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] tid;
    logic [7:0] data;
    logic       first;
    logic       last;
  } sec_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_table_id;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_stream_type;
  logic [12:0] out_es_pid;
  logic [11:0] out_es_info_length;
  logic [7:0]  out_entry_index;
  logic [15:0] out_pcr_pid;
  logic [7:0]  out_entry_count;
  logic [1:0]  out_status;
  logic        out_final_res;

  int err_cnt;
  int expect_cnt;
  int cycle_cnt = 0;
  int fed = 0;
  bit idle_on = 1'b1;

  sec_byte_t sec_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pmt_section_parser_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_table_id        (in_table_id),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_stream_type    (out_stream_type),
    .out_es_pid         (out_es_pid),
    .out_es_info_length (out_es_info_length),
    .out_entry_index    (out_entry_index),
    .out_pcr_pid        (out_pcr_pid),
    .out_entry_count    (out_entry_count),
    .out_status         (out_status),
    .out_final_res      (out_final_res)
  );

  pmt_section_parser_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_table_id        (in_table_id),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_stream_type    (out_stream_type),
    .out_es_pid         (out_es_pid),
    .out_es_info_length (out_es_info_length),
    .out_entry_index    (out_entry_index),
    .out_pcr_pid        (out_pcr_pid),
    .out_entry_count    (out_entry_count),
    .out_status         (out_status),
    .out_final_res      (out_final_res),
    .err_cnt            (err_cnt),
    .expect_cnt         (expect_cnt)
  );

  task automatic put(input logic [7:0] tid, input logic [7:0] d,
                     input logic first, input logic last);
    sec_byte_t v;
    v = {tid, d, first, last};
    sec_q.insert(sec_q.size(), v);
  endtask

  task automatic add_byte(input logic [7:0] d);
    put(TID_PMT, d, sec_q.size() == 0, 1'b0);
  endtask

  task automatic mark_last();
    sec_byte_t v;
    v = sec_q[sec_q.size() - 1];
    v.last = 1'b1;
    sec_q[sec_q.size() - 1] = v;
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
  endfunction

  // well-formed section with random reserved bits and descriptor content
  task automatic build_pmt(input int n_es, input int prog_len);
    logic [12:0] pid;
    logic [11:0] len12;
    int          es_len;
    pid = 13'($urandom_range(0, 8191));
    len12 = 12'(prog_len);
    add_byte({3'($urandom_range(0, 7)), pid[12:8]});
    add_byte(pid[7:0]);
    add_byte({4'($urandom_range(0, 15)), len12[11:8]});
    add_byte(len12[7:0]);
    repeat (prog_len) add_byte(8'($urandom));
    repeat (n_es) begin
      add_byte(8'($urandom));
      pid = 13'($urandom_range(0, 8191));
      add_byte({3'($urandom_range(0, 7)), pid[12:8]});
      add_byte(pid[7:0]);
      es_len = pick_len();
      len12 = 12'(es_len);
      add_byte({4'($urandom_range(0, 15)), len12[11:8]});
      add_byte(len12[7:0]);
      repeat (es_len) add_byte(8'($urandom));
    end
    mark_last();
  endtask

  // called at a rising edge; returns at the edge where the byte transfers
  task automatic drive_byte(input sec_byte_t x);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_table_id   <= x.tid;
    in_data_byte  <= x.data;
    in_first_byte <= x.first;
    in_last_byte  <= x.last;
    do @(posedge clk); while (!in_ready);
    if (x.tid == TID_PMT)
      fed++;
  endtask

  task automatic send_section();
    foreach (sec_q[i])
      drive_byte(sec_q[i]);
    sec_q.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expect_cnt != 0);
    @(posedge clk);
  endtask

  // result side back-pressure
  initial begin : sink
    int hold;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 14);
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("pmt_section_parser_top_tb: done, errors");
    $finish;
  end

  initial begin : stim
    int        pick;
    int        cut;
    int        k;
    int        n;
    bit        big_done;
    sec_byte_t v;
    big_done = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_table_id   <= '0;
    in_data_byte  <= '0;
    in_first_byte <= 1'b0;
    in_last_byte  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte section with a bad table id
    put(8'h00, 8'hFF, 1'b1, 1'b1);
    // program info skip, one entry with no descriptors ending on the last byte
    put(TID_PMT, 8'hE1, 1'b1, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b0);
    put(TID_PMT, 8'hF0, 1'b0, 1'b0);
    put(TID_PMT, 8'h01, 1'b0, 1'b0);
    put(TID_PMT, 8'hAA, 1'b0, 1'b0);
    put(TID_PMT, 8'h1B, 1'b0, 1'b0);
    put(TID_PMT, 8'hE1, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b0);
    put(TID_PMT, 8'hF0, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b1);
    // no first marker, partial entry, bad table id on the last byte
    put(TID_PMT, 8'h00, 1'b0, 1'b0);
    put(TID_PMT, 8'h20, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b0);
    put(TID_PMT, 8'h02, 1'b0, 1'b0);
    put(TID_PMT, 8'hFF, 1'b0, 1'b0);
    put(8'h7F, 8'hFF, 1'b0, 1'b1);
    // rejected section restarted by a first marker
    put(TID_PMT, 8'h01, 1'b1, 1'b0);
    put(8'hFF, 8'h02, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b1, 1'b0);
    put(TID_PMT, 8'h10, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b0);
    put(TID_PMT, 8'h00, 1'b0, 1'b1);
    // first and last on the same byte
    put(TID_PMT, 8'h00, 1'b1, 1'b1);
    send_section();

    while (fed < ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0) && (fed < ITEMS - CALM_ITEMS);
      if (!big_done && fed > 300) begin
        // let everything drain, then one section past the payload limit
        drain();
        build_pmt(2, 1040);
        send_section();
        big_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        build_pmt($urandom_range(0, 6), pick_len());
        if (pick >= 60 && pick < 74) begin
          cut = $urandom_range(1, sec_q.size() - 1);
          while (sec_q.size() > cut)
            void'(sec_q.pop_back());
          mark_last();
        end else if (pick >= 74 && pick < 82) begin
          k = $urandom_range(0, sec_q.size() - 1);
          v = sec_q[k];
          v.tid = 8'($urandom_range(3, 257));
          sec_q[k] = v;
        end else if (pick >= 82 && pick < 87) begin
          v = sec_q[0];
          v.first = 1'b0;
          sec_q[0] = v;
        end else if (pick >= 87 && pick < 92) begin
          k = $urandom_range(1, sec_q.size() - 1);
          v = sec_q[k];
          v.first = 1'b1;
          sec_q[k] = v;
        end else if (pick >= 92) begin
          // raw noise: random table ids, markers and bytes
          sec_q.delete();
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++)
            put($urandom_range(0, 1) ? TID_PMT : 8'($urandom), 8'($urandom),
                (i == 0) || ($urandom_range(0, 7) == 0),
                (i == n - 1) || ($urandom_range(0, 5) == 0));
        end
        send_section();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_cnt == 0)
      $display("pmt_section_parser_top_tb: done, clean");
    else
      $display("pmt_section_parser_top_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pmt_pkg.sv
rtl/pmt_parser.sv
rtl/pmt_res_fifo.sv
rtl/pmt_section_parser_top.sv
verif/pmt_section_parser_checker.sv
verif/pmt_section_parser_top_tb.sv
